>>> rtl/ttt_pkg.sv
package ttt_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam logic [2:0] FN_ADD  = 3'd0;
    localparam logic [2:0] FN_DEL  = 3'd1;
    localparam logic [2:0] FN_TICK = 3'd2;
    localparam logic [2:0] FN_DISP = 3'd3;
    localparam logic [2:0] FN_TIME = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_NONE_READY = 3'd3;
    localparam logic [2:0] ST_WRAPPED    = 3'd4;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_DEL  = 2'd2;
    localparam logic [1:0] ERR_TICK = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  job_handle;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [31:0] target_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] task_id;
        logic [7:0]  run_handle;
        logic        freed_after_run;
        logic [31:0] time_now;
        logic [1:0]  last_error;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic              latch;
        logic [SLOT_W-1:0] idx;
        logic              add;
        logic              del;
        logic              tick_slot;
        logic              tick_count;
        logic              disp;
        logic              emit;
        logic [2:0]        status;
        logic              err_set;
        logic [1:0]        err_code;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       valid;
        logic       ready;
        logic       id_match;
        logic       more_ready;
        logic       tick_wrap;
        logic       out_free;
    } t_dp_stat;

endpackage

>>> rtl/ttt_ctrl.sv
module ttt_ctrl
    import ttt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_any, n_any;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        logic done;
        logic last_slot;
        logic hit;
        logic advance;
        done      = 1'b0;
        advance   = 1'b0;
        last_slot = (r_idx == SLOT_W'(MAX_TASKS - 1));
        hit       = i_stat.valid && i_stat.ready;
        o_cmd     = '0;
        o_cmd.idx  = r_idx;
        o_cmd.last = 1'b1;
        o_cmd.status = ST_OK;
        n_state = r_state;
        n_idx   = r_idx;
        n_any   = r_any;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_SCAN;
                    n_idx   = '0;
                    n_any   = 1'b0;
                end
            end
            S_SCAN: begin
                case (i_stat.func)
                    FN_ADD: begin
                        if (!i_stat.valid) begin
                            o_cmd.add  = 1'b1;
                            o_cmd.emit = 1'b1;
                            done = 1'b1;
                        end else if (last_slot) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.status   = ST_FULL;
                            o_cmd.err_set  = 1'b1;
                            o_cmd.err_code = ERR_FULL;
                            done = 1'b1;
                        end
                    end
                    FN_DEL: begin
                        if (i_stat.valid && i_stat.id_match) begin
                            o_cmd.del  = 1'b1;
                            o_cmd.emit = 1'b1;
                            done = 1'b1;
                        end else if (last_slot) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.status   = ST_NOT_FOUND;
                            o_cmd.err_set  = 1'b1;
                            o_cmd.err_code = ERR_DEL;
                            done = 1'b1;
                        end
                    end
                    FN_TICK: begin
                        o_cmd.tick_slot = 1'b1;
                        if (last_slot) begin
                            o_cmd.tick_count = 1'b1;
                            o_cmd.emit       = 1'b1;
                            o_cmd.status     = i_stat.tick_wrap ? ST_WRAPPED : ST_OK;
                            o_cmd.err_set    = i_stat.tick_wrap;
                            o_cmd.err_code   = ERR_TICK;
                            done = 1'b1;
                        end
                    end
                    FN_DISP: begin
                        if (hit) begin
                            o_cmd.disp = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = !i_stat.more_ready;
                            n_any = 1'b1;
                        end else if (last_slot && !r_any) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_NONE_READY;
                        end
                        done = last_slot;
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                        done = 1'b1;
                    end
                endcase
                advance = !o_cmd.emit || i_stat.out_free;
                if (!advance) begin
                    o_cmd.add        = 1'b0;
                    o_cmd.del        = 1'b0;
                    o_cmd.tick_slot  = 1'b0;
                    o_cmd.tick_count = 1'b0;
                    o_cmd.disp       = 1'b0;
                    o_cmd.emit       = 1'b0;
                    o_cmd.err_set    = 1'b0;
                    n_any = r_any;
                end else if (done) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_any   <= n_any;
        end
    end

endmodule

>>> rtl/ttt_datapath.sv
module ttt_datapath
    import ttt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_in_item             r_item;
    logic [MAX_TASKS-1:0] r_valid;
    logic [MAX_TASKS-1:0] r_ready;
    logic [31:0]          r_delay  [MAX_TASKS];
    logic [31:0]          r_period [MAX_TASKS];
    logic [31:0]          r_id     [MAX_TASKS];
    logic [7:0]           r_handle [MAX_TASKS];
    logic [31:0]          r_id_ctr;
    logic [31:0]          r_tick;
    logic [1:0]           r_err;
    logic                 r_out_vld;
    t_out_item            r_out;

    logic [31:0] n_id;
    logic [31:0] n_tick;
    logic [1:0]  n_err;
    logic [31:0] cur_delay;
    logic [31:0] dec_delay;
    logic        cur_valid;
    logic        period_zero;
    logic        more_ready;
    t_out_item   n_out;

    assign cur_valid   = r_valid[i_cmd.idx];
    assign cur_delay   = r_delay[i_cmd.idx];
    assign dec_delay   = (cur_delay != 32'd0) ? cur_delay - 32'd1 : cur_delay;
    assign period_zero = (r_period[i_cmd.idx] == 32'd0);
    assign n_id        = r_id_ctr + 32'd1;
    assign n_tick      = i_cmd.tick_count ? r_tick + 32'd1 : r_tick;
    assign n_err       = i_cmd.err_set ? i_cmd.err_code : r_err;

    always_comb begin
        more_ready = 1'b0;
        for (int j = 0; j < MAX_TASKS; j++) begin
            if ((SLOT_W'(j) > i_cmd.idx) && r_valid[j] && r_ready[j]) begin
                more_ready = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.func       = r_item.func;
        o_stat.valid      = cur_valid;
        o_stat.ready      = r_ready[i_cmd.idx];
        o_stat.id_match   = (r_id[i_cmd.idx] == r_item.target_id);
        o_stat.more_ready = more_ready;
        o_stat.tick_wrap  = &r_tick;
        o_stat.out_free   = !r_out_vld || !i_out_stall;
    end

    always_comb begin
        n_out.status          = i_cmd.status;
        n_out.task_id         = i_cmd.add ? n_id : (i_cmd.disp ? r_id[i_cmd.idx] : 32'd0);
        n_out.run_handle      = i_cmd.disp ? r_handle[i_cmd.idx] : 8'd0;
        n_out.freed_after_run = i_cmd.disp && period_zero;
        n_out.time_now        = n_tick;
        n_out.last_error      = n_err;
        n_out.last            = i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_ready   <= '0;
            r_id_ctr  <= '0;
            r_tick    <= '0;
            r_err     <= ERR_NONE;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.add) begin
                r_valid[i_cmd.idx] <= 1'b1;
                r_ready[i_cmd.idx] <= 1'b0;
                r_id_ctr           <= n_id;
            end
            if (i_cmd.del) begin
                r_valid[i_cmd.idx] <= 1'b0;
                r_ready[i_cmd.idx] <= 1'b0;
            end
            if (i_cmd.tick_slot && cur_valid && (dec_delay == 32'd0)) begin
                r_ready[i_cmd.idx] <= 1'b1;
            end
            if (i_cmd.disp) begin
                r_ready[i_cmd.idx] <= 1'b0;
                if (period_zero) begin
                    r_valid[i_cmd.idx] <= 1'b0;
                end
            end
            r_tick <= n_tick;
            r_err  <= n_err;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_item;
        end
        if (i_cmd.add) begin
            r_delay[i_cmd.idx]  <= r_item.start_delay;
            r_period[i_cmd.idx] <= r_item.repeat_period;
            r_id[i_cmd.idx]     <= n_id;
            r_handle[i_cmd.idx] <= r_item.job_handle;
        end
        if (i_cmd.tick_slot && cur_valid) begin
            r_delay[i_cmd.idx] <= dec_delay;
        end
        if (i_cmd.disp && !period_zero) begin
            r_delay[i_cmd.idx] <= r_period[i_cmd.idx];
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

>>> rtl/task_timer_table.sv
// task_timer_table: cooperative scheduler timer table with MAX_TASKS slots
// input channel: i_in_valid / o_in_stall carry one operation (add, delete,
// tick, dispatch, read time) in i_in_item; a transfer happens when valid is
// high and stall is low
// output channel: o_out_valid / i_out_stall carry result items in
// o_out_item; the last result of an operation has last set
// a sequencer walks the slots one per cycle unless the output stalls it;
// an operation occupies the block until its walk ends: add and delete stop
// at the first free or matching slot or else at the last, tick and dispatch
// always walk all; dispatch gives one result per ready slot in slot order
// the first result appears in the cycle after the slot that produces it;
// o_in_stall is high from the cycle after a transfer until the walk ends
// results sit in an output register; while i_out_stall is high and a
// result is waiting, the walk holds at a slot that must emit
// synchronous active-low reset clears all slots, the id counter, the tick
// counter, the sticky error and the output valid flag
module task_timer_table
    import ttt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ttt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ttt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/ttt_checker.sv
module ttt_checker
    import ttt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an operation is in progress");

    a_full_sets_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_FULL) |->
            (o_out_item.last_error == ERR_FULL) && (o_out_item.task_id == 32'd0))
        else $error("table full result without matching error");

    a_none_ready_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_NONE_READY) |->
            o_out_item.last && (o_out_item.run_handle == 8'd0))
        else $error("nothing ready result malformed");

    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.freed_after_run |-> (o_out_item.status == ST_OK))
        else $error("freed slot reported with error status");

endmodule

bind task_timer_table ttt_checker u_ttt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
